[rtl/km_pkg.sv]
// ----------------------------------------------------------------------------
// km_pkg
// Shared types and constants for the k-means clustering block.
// ----------------------------------------------------------------------------
package km_pkg;

	localparam logic [1:0] CFG_CLUSTERS   = 2'd0;
	localparam logic [1:0] CFG_POINTS     = 2'd1;
	localparam logic [1:0] CFG_DIMENSIONS = 2'd2;
	localparam logic [1:0] CFG_ITER_CAP   = 2'd3;

	localparam int CLUSTER_ID_W  = 4;
	localparam int POINT_INDEX_W = 6;
	localparam int PASSES_W      = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CLR,
		ST_ACC,
		ST_ACC_WAIT,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DIST,
		ST_DIST_WAIT,
		ST_LOAD,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT,
		ST_DRAIN
	} km_state_t;

	typedef struct packed {
		logic clear;
		logic acc_en;
		logic acc_last;
		logic dist_clr;
		logic dist_en;
		logic chain_load;
		logic chain_shift;
		logic cent_we;
	} km_ctl_t;

endpackage

[rtl/km_div.sv]
// ----------------------------------------------------------------------------
// km_div
// Serial restoring divider: signed sum over unsigned count, truncating.
// ----------------------------------------------------------------------------
module km_div #(
	parameter int SUMW = 23,
	parameter int CNTW = 7,
	parameter int CW   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [SUMW-1:0] num,
	input  logic [CNTW-1:0]        den,
	output logic                   done,
	output logic signed [CW-1:0]   quo
);
	localparam int STW = $clog2(SUMW + 1);

	logic [SUMW-1:0] q_q;
	logic [CNTW:0]   rem_q;
	logic [CNTW-1:0] den_q;
	logic            neg_q;
	logic [STW-1:0]  step_q;
	logic            run_q;
	logic            done_q;
	logic [CNTW:0]   shifted;
	logic            fits;

	assign shifted = {rem_q[CNTW-1:0], q_q[SUMW-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STW'(SUMW);
			end else if (run_q) begin
				step_q <= step_q - STW'(1);
				if (step_q == STW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[SUMW-1] ? (~num + SUMW'(1)) : num;
			neg_q <= num[SUMW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			q_q   <= {q_q[SUMW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? CW'(~q_q + SUMW'(1)) : CW'(q_q);

endmodule

[rtl/km_cell.sv]
// ----------------------------------------------------------------------------
// km_cell
// One cluster cell: centroid, coordinate sums, member count, distance unit
// and one stage of the distance chain toward cell 0.
// ----------------------------------------------------------------------------
module km_cell #(
	parameter int CW       = 16,
	parameter int MAX_DIMS = 8,
	parameter int DIW      = 3,
	parameter int CIW      = 4,
	parameter int SW       = 36,
	parameter int SUMW     = 23,
	parameter int CNTW     = 7,
	parameter int CELL_ID  = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  km_pkg::km_ctl_t        ctl,
	input  logic signed [CW-1:0]   coord,
	input  logic [DIW-1:0]         dim_rd,
	input  logic [CIW-1:0]         asg,
	input  logic [DIW-1:0]         dim_wr,
	input  logic [CIW-1:0]         sel_id,
	input  logic signed [CW-1:0]   cent_data,
	input  logic [SW-1:0]          next_dist,
	input  logic                   next_vld,
	output logic [SW-1:0]          dist_out,
	output logic                   vld,
	output logic signed [SUMW-1:0] sum_out,
	output logic [CNTW-1:0]        cnt_out
);
	localparam int SH = (SW > 64) ? SW - 64 : 0;
	localparam logic [SW-1:0] SATV = {SW{1'b1}} >> SH;

	logic signed [SUMW-1:0] sum_q [MAX_DIMS];
	logic signed [CW-1:0]   cent_q [MAX_DIMS];
	logic [CNTW-1:0]        cnt_q;
	logic signed [CW:0]     diff_s1;
	logic [2*CW-1:0]        sq_s2;
	logic                   v_s1;
	logic                   v_s2;
	logic [SW-1:0]          acc_q;
	logic [SW-1:0]          acc_sat;
	logic [SW-1:0]          sh_d_q;
	logic                   sh_v_q;
	logic signed [2*CW+1:0] prod;
	logic                   mine;

	assign mine    = asg == CIW'(CELL_ID);
	assign prod    = diff_s1 * diff_s1;
	assign acc_sat = (acc_q > SATV) ? SATV : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				sum_q[i] <= '0;
			end
			cnt_q <= '0;
		end else if (ctl.acc_en && mine) begin
			sum_q[dim_rd] <= sum_q[dim_rd] + SUMW'(coord);
			if (ctl.acc_last) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
		if (ctl.cent_we && sel_id == CIW'(CELL_ID)) begin
			cent_q[dim_wr] <= cent_data;
		end
		diff_s1 <= (CW+1)'(coord) - (CW+1)'(cent_q[dim_rd]);
		sq_s2   <= prod[2*CW-1:0];
		if (ctl.dist_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + SW'(sq_s2);
		end
		if (ctl.chain_load) begin
			sh_d_q <= acc_sat;
		end else if (ctl.chain_shift) begin
			sh_d_q <= next_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			sh_v_q <= 1'b0;
		end else begin
			v_s1 <= ctl.dist_en;
			v_s2 <= v_s1;
			if (ctl.chain_load) begin
				sh_v_q <= cnt_q != '0;
			end else if (ctl.chain_shift) begin
				sh_v_q <= next_vld;
			end
		end
	end

	assign dist_out = sh_d_q;
	assign vld      = sh_v_q;
	assign sum_out  = sum_q[dim_wr];
	assign cnt_out  = cnt_q;

endmodule

[rtl/kmeans_clustering.sv]
// ----------------------------------------------------------------------------
// kmeans_clustering
// Lloyd k-means over a loaded point set, one row of cluster cells.
// ----------------------------------------------------------------------------
// Load: one coordinate word per accepted start (start high, busy low), point
// major. The word with final_coord set is stored, then busy rises and the
// run starts; loading restarts at address 0 afterwards.
// Config: cfg_valid/cfg_index/cfg_data, cfg_ready always high; write only
// while busy is low. Values are clamped when a run starts.
// Run: init assigns point p to cluster p mod K. Each pass then sums the points,
// divides each centroid coordinate in the shared serial divider and computes
// distances, where the distance chain is scanned one cluster a cycle.
// Results: N words, one per cycle, each marked by result_valid for one
// cycle; end_of_run flags the last. The receiver cannot stall. busy drops
// the cycle after the last word. Load words can be taken back to back while busy is low.
// Reset: config returns to defaults, block idle, load address zero.
// ----------------------------------------------------------------------------
module kmeans_clustering #(
	parameter int MAX_POINTS   = 64,
	parameter int MAX_DIMS     = 8,
	parameter int MAX_CLUSTERS = 16,
	parameter int COORD_WIDTH  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_WIDTH-1:0]        coordinate,
	input  logic                                 final_coord,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [7:0]                           cfg_data,
	output logic                                 result_valid,
	output logic [km_pkg::POINT_INDEX_W-1:0]     point_index,
	output logic [km_pkg::CLUSTER_ID_W-1:0]      cluster_id,
	output logic [km_pkg::PASSES_W-1:0]          passes_run,
	output logic                                 converged,
	output logic                                 end_of_run
);
	localparam int CW    = COORD_WIDTH;
	localparam int DEPTH = MAX_POINTS * MAX_DIMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = $clog2(MAX_POINTS);
	localparam int PCW   = $clog2(MAX_POINTS + 1);
	localparam int DIW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DCW   = $clog2(MAX_DIMS + 1);
	localparam int CIW   = $clog2(MAX_CLUSTERS);
	localparam int KW    = $clog2(MAX_CLUSTERS + 1);
	localparam int SUMW  = CW + PW + 1;
	localparam int CNTW  = PCW;
	localparam int SW    = 2 * CW + $clog2(MAX_DIMS) + 1;

	km_pkg::km_state_t state_q, state_n;
	km_pkg::km_ctl_t   ctl;

	logic [4:0]  k_cfg_q;
	logic [6:0]  n_cfg_q;
	logic [3:0]  d_cfg_q;
	logic [7:0]  cap_cfg_q;
	logic [KW-1:0]  k_q;
	logic [PCW-1:0] npts_q;
	logic [DCW-1:0] dims_q;
	logic [7:0]     cap_q;
	logic [KW-1:0]  k_n;
	logic [PCW-1:0] npts_n;
	logic [DCW-1:0] dims_n;
	logic [7:0]     cap_n;

	logic [AW-1:0]  load_q;
	logic [AW-1:0]  addr_q;
	logic [PW-1:0]  p_q;
	logic [DIW-1:0] d_q;
	logic [CIW-1:0] c_q;
	logic [CIW-1:0] sc_q;
	logic [CIW-1:0] modc_q;
	logic [1:0]     wait_q;
	logic           moved_q;
	logic [7:0]     passes_q;
	logic           conv_q;

	logic           m_acc_q;
	logic           m_dist_q;
	logic           m_last_q;
	logic [DIW-1:0] d_m_q;

	logic           found_q;
	logic [SW-1:0]  min_d_q;
	logic [CIW-1:0] min_c_q;
	logic [SW-1:0]  d_asg_q;

	logic                 res_v_q;
	logic [PW-1:0]        res_p_q;
	logic                 res_last_q;

	logic signed [CW-1:0] pt_mem [DEPTH];
	logic [CIW-1:0]       asg_mem [MAX_POINTS];
	logic signed [CW-1:0] pt_rd_q;
	logic [CIW-1:0]       asg_rd_q;
	logic                 asg_we;
	logic [CIW-1:0]       asg_wdata;

	logic                 load_acc;
	logic                 last_d;
	logic                 last_p;
	logic                 last_c;
	logic                 last_sc;
	logic [CIW-1:0]       new_c;
	logic                 changed;
	logic                 moved_n;
	logic [7:0]           passes_n;
	logic                 stop_n;

	logic                 div_start;
	logic                 div_done;
	logic signed [CW-1:0] div_quo;
	logic signed [CW-1:0] cent_data;

	logic [SW-1:0]          ch_d   [MAX_CLUSTERS+1];
	logic                   ch_v   [MAX_CLUSTERS+1];
	logic signed [SUMW-1:0] sum_w  [MAX_CLUSTERS];
	logic [CNTW-1:0]        cnt_w  [MAX_CLUSTERS];

	assign load_acc = start && !busy;
	assign last_d   = (DCW'(d_q) + DCW'(1)) == dims_q;
	assign last_p   = (PCW'(p_q) + PCW'(1)) == npts_q;
	assign last_c   = (KW'(c_q) + KW'(1)) == k_q;
	assign last_sc  = (KW'(sc_q) + KW'(1)) == k_q;
	assign new_c    = (found_q && min_d_q < d_asg_q) ? min_c_q : asg_rd_q;
	assign changed  = new_c != asg_rd_q;
	assign moved_n  = moved_q || changed;
	assign passes_n = passes_q + 8'd1;
	assign stop_n   = !moved_n || passes_n == cap_q;

	always_comb begin
		if (k_cfg_q == '0) begin
			k_n = KW'(1);
		end else if (32'(k_cfg_q) > MAX_CLUSTERS) begin
			k_n = KW'(MAX_CLUSTERS);
		end else begin
			k_n = KW'(k_cfg_q);
		end
		if (n_cfg_q == '0) begin
			npts_n = PCW'(1);
		end else if (32'(n_cfg_q) > MAX_POINTS) begin
			npts_n = PCW'(MAX_POINTS);
		end else begin
			npts_n = PCW'(n_cfg_q);
		end
		if (d_cfg_q == '0) begin
			dims_n = DCW'(1);
		end else if (32'(d_cfg_q) > MAX_DIMS) begin
			dims_n = DCW'(MAX_DIMS);
		end else begin
			dims_n = DCW'(d_cfg_q);
		end
		cap_n = (cap_cfg_q == '0) ? 8'd1 : cap_cfg_q;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			km_pkg::ST_IDLE:      if (load_acc && final_coord) state_n = km_pkg::ST_INIT;
			km_pkg::ST_INIT:      if (last_p) state_n = km_pkg::ST_CLR;
			km_pkg::ST_CLR:       state_n = km_pkg::ST_ACC;
			km_pkg::ST_ACC:       if (last_p && last_d) state_n = km_pkg::ST_ACC_WAIT;
			km_pkg::ST_ACC_WAIT:  state_n = km_pkg::ST_DIV_START;
			km_pkg::ST_DIV_START: state_n = km_pkg::ST_DIV_WAIT;
			km_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_n = (last_c && last_d) ? km_pkg::ST_DIST : km_pkg::ST_DIV_START;
				end
			end
			km_pkg::ST_DIST:      if (last_d) state_n = km_pkg::ST_DIST_WAIT;
			km_pkg::ST_DIST_WAIT: if (wait_q == 2'd2) state_n = km_pkg::ST_LOAD;
			km_pkg::ST_LOAD:      state_n = km_pkg::ST_SCAN;
			km_pkg::ST_SCAN:      if (last_sc) state_n = km_pkg::ST_DECIDE;
			km_pkg::ST_DECIDE: begin
				if (!last_p) begin
					state_n = km_pkg::ST_DIST;
				end else begin
					state_n = stop_n ? km_pkg::ST_EMIT : km_pkg::ST_CLR;
				end
			end
			km_pkg::ST_EMIT:      if (last_p) state_n = km_pkg::ST_DRAIN;
			km_pkg::ST_DRAIN:     state_n = km_pkg::ST_IDLE;
			default:              state_n = km_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl             = '0;
		ctl.clear       = state_q == km_pkg::ST_CLR;
		ctl.acc_en      = m_acc_q;
		ctl.acc_last    = m_last_q;
		ctl.dist_en     = m_dist_q;
		ctl.dist_clr    = state_q == km_pkg::ST_DIST && d_q == '0;
		ctl.chain_load  = state_q == km_pkg::ST_LOAD;
		ctl.chain_shift = state_q == km_pkg::ST_SCAN;
		ctl.cent_we     = state_q == km_pkg::ST_DIV_WAIT && div_done;
		div_start       = state_q == km_pkg::ST_DIV_START;
		asg_we          = state_q == km_pkg::ST_INIT
			|| (state_q == km_pkg::ST_DECIDE && changed);
		asg_wdata       = (state_q == km_pkg::ST_INIT) ? modc_q : new_c;
		busy            = state_q != km_pkg::ST_IDLE;
	end

	assign cent_data = (cnt_w[c_q] == '0) ? '0 : div_quo;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (load_acc) begin
			pt_mem[load_q] <= coordinate;
		end
		pt_rd_q <= pt_mem[addr_q];
		if (asg_we) begin
			asg_mem[p_q] <= asg_wdata;
		end
		asg_rd_q <= asg_mem[p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= km_pkg::ST_IDLE;
			k_cfg_q    <= 5'd2;
			n_cfg_q    <= 7'd64;
			d_cfg_q    <= 4'd3;
			cap_cfg_q  <= 8'd32;
			k_q        <= '0;
			npts_q     <= '0;
			dims_q     <= '0;
			cap_q      <= '0;
			load_q     <= '0;
			addr_q     <= '0;
			p_q        <= '0;
			d_q        <= '0;
			c_q        <= '0;
			sc_q       <= '0;
			modc_q     <= '0;
			wait_q     <= '0;
			moved_q    <= 1'b0;
			passes_q   <= '0;
			conv_q     <= 1'b0;
			m_acc_q    <= 1'b0;
			m_dist_q   <= 1'b0;
			m_last_q   <= 1'b0;
			d_m_q      <= '0;
			found_q    <= 1'b0;
			min_d_q    <= '0;
			min_c_q    <= '0;
			d_asg_q    <= '0;
			res_v_q    <= 1'b0;
			res_p_q    <= '0;
			res_last_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			m_acc_q  <= state_q == km_pkg::ST_ACC;
			m_dist_q <= state_q == km_pkg::ST_DIST;
			m_last_q <= last_d;
			d_m_q    <= d_q;
			res_v_q  <= state_q == km_pkg::ST_EMIT;
			res_p_q  <= p_q;
			res_last_q <= last_p;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					km_pkg::CFG_CLUSTERS:   k_cfg_q   <= cfg_data[4:0];
					km_pkg::CFG_POINTS:     n_cfg_q   <= cfg_data[6:0];
					km_pkg::CFG_DIMENSIONS: d_cfg_q   <= cfg_data[3:0];
					km_pkg::CFG_ITER_CAP:   cap_cfg_q <= cfg_data;
					default:                k_cfg_q   <= k_cfg_q;
				endcase
			end

			unique case (state_q)
				km_pkg::ST_IDLE: begin
					if (load_acc) begin
						if (final_coord) begin
							load_q   <= '0;
							k_q      <= k_n;
							npts_q   <= npts_n;
							dims_q   <= dims_n;
							cap_q    <= cap_n;
							p_q      <= '0;
							modc_q   <= '0;
							passes_q <= '0;
						end else if (32'(load_q) == DEPTH - 1) begin
							load_q <= '0;
						end else begin
							load_q <= load_q + AW'(1);
						end
					end
				end
				km_pkg::ST_INIT: begin
					p_q    <= last_p ? '0 : p_q + PW'(1);
					modc_q <= ((KW'(modc_q) + KW'(1)) == k_q) ? '0 : modc_q + CIW'(1);
				end
				km_pkg::ST_CLR: begin
					p_q     <= '0;
					d_q     <= '0;
					addr_q  <= '0;
					moved_q <= 1'b0;
				end
				km_pkg::ST_ACC: begin
					addr_q <= addr_q + AW'(1);
					if (last_d) begin
						d_q <= '0;
						p_q <= p_q + PW'(1);
					end else begin
						d_q <= d_q + DIW'(1);
					end
				end
				km_pkg::ST_ACC_WAIT: begin
					c_q <= '0;
					d_q <= '0;
				end
				km_pkg::ST_DIV_WAIT: begin
					if (div_done) begin
						if (last_d) begin
							d_q <= '0;
							c_q <= c_q + CIW'(1);
						end else begin
							d_q <= d_q + DIW'(1);
						end
						if (last_c && last_d) begin
							p_q    <= '0;
							addr_q <= '0;
						end
					end
				end
				km_pkg::ST_DIST: begin
					addr_q <= addr_q + AW'(1);
					d_q    <= last_d ? '0 : d_q + DIW'(1);
					wait_q <= '0;
				end
				km_pkg::ST_DIST_WAIT: begin
					wait_q <= wait_q + 2'd1;
				end
				km_pkg::ST_LOAD: begin
					sc_q    <= '0;
					found_q <= 1'b0;
				end
				km_pkg::ST_SCAN: begin
					sc_q <= sc_q + CIW'(1);
					if (ch_v[0] && (!found_q || ch_d[0] < min_d_q)) begin
						found_q <= 1'b1;
						min_d_q <= ch_d[0];
						min_c_q <= sc_q;
					end
					if (sc_q == asg_rd_q) begin
						d_asg_q <= ch_d[0];
					end
				end
				km_pkg::ST_DECIDE: begin
					moved_q <= moved_n;
					if (!last_p) begin
						p_q <= p_q + PW'(1);
					end else begin
						passes_q <= passes_n;
						conv_q   <= !moved_n;
						p_q      <= '0;
					end
				end
				km_pkg::ST_EMIT: begin
					p_q <= p_q + PW'(1);
				end
				default: begin
					wait_q <= wait_q;
				end
			endcase
		end
	end

	km_div #(
		.SUMW (SUMW),
		.CNTW (CNTW),
		.CW   (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_w[c_q]),
		.den    (cnt_w[c_q]),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign ch_d[MAX_CLUSTERS] = '0;
	assign ch_v[MAX_CLUSTERS] = 1'b0;

	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		km_cell #(
			.CW       (CW),
			.MAX_DIMS (MAX_DIMS),
			.DIW      (DIW),
			.CIW      (CIW),
			.SW       (SW),
			.SUMW     (SUMW),
			.CNTW     (CNTW),
			.CELL_ID  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.coord     (pt_rd_q),
			.dim_rd    (d_m_q),
			.asg       (asg_rd_q),
			.dim_wr    (d_q),
			.sel_id    (c_q),
			.cent_data (cent_data),
			.next_dist (ch_d[i+1]),
			.next_vld  (ch_v[i+1]),
			.dist_out  (ch_d[i]),
			.vld       (ch_v[i]),
			.sum_out   (sum_w[i]),
			.cnt_out   (cnt_w[i])
		);
	end

	assign result_valid = res_v_q;
	assign point_index  = km_pkg::POINT_INDEX_W'(res_p_q);
	assign cluster_id   = km_pkg::CLUSTER_ID_W'(asg_rd_q);
	assign passes_run   = passes_q;
	assign converged    = conv_q;
	assign end_of_run   = res_v_q && res_last_q;

`ifndef NO_ASSERTIONS
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && final_coord) |=> busy)
		else $error("run did not start after final word");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result word outside a run");
	a_passes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (passes_run != 8'd0 && passes_run <= cap_q))
		else $error("pass count out of range");
	a_conv_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !converged) |-> passes_run == cap_q)
		else $error("unconverged run stopped before the cap");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_start)
		else $error("divider restarted back to back");
`endif

endmodule

[tb/tb_kmeans_clustering.sv]
// ----------------------------------------------------------------------------
// tb_kmeans_clustering
// Self-checking bench for the Lloyd k-means block: loads point sets word by
// word, predicts every point's final cluster, pass count and convergence flag,
// and checks each result word in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_kmeans_clustering;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS  = 64;
	localparam int NDIM  = 8;
	localparam int NCLU  = 16;
	localparam int DEPTH = NPTS * NDIM;
	localparam int SETTLE = 16;

	typedef struct {
		logic signed [15:0] coord;
		logic               fin;
	} load_word_t;

	typedef struct {
		logic [5:0] idx;
		logic [3:0] cl;
		logic [7:0] passes;
		logic       conv;
		logic       last;
	} label_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [15:0] coordinate = 0;
	logic final_coord = 0;
	logic cfg_valid = 0;
	logic [1:0] cfg_index = km_pkg::CFG_CLUSTERS;
	logic [7:0] cfg_data = 0;
	logic busy, cfg_ready, result_valid, converged, end_of_run;
	logic [5:0] point_index;
	logic [3:0] cluster_id;
	logic [7:0] passes_run;

	kmeans_clustering uut (.*);

	load_word_t load_q[$];
	label_t     label_q[$];
	int errors = 0;
	int sender_idle = 11;
	int runs_done = 0;
	int labels_seen = 0;
	int words_sent = 0;

	// predictor state
	logic signed [15:0] coord_store[DEPTH];
	logic [3:0] member_of[NPTS];
	longint centroid[NCLU][NDIM];
	int load_pos = 0;
	logic [4:0] k_reg = 2;
	logic [6:0] n_reg = 64;
	logic [3:0] d_reg = 3;
	logic [7:0] cap_reg = 32;

	initial forever #2 clk = ~clk;

	initial begin
		#400ms;
		$display("FAILURE");
		$finish;
	end

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sq_dist(int p, int c, int dims);
		longint acc, df;
		acc = 0;
		for (int d = 0; d < dims; d++) begin
			df = longint'(coord_store[p * dims + d]) - centroid[c][d];
			acc += df * df;
		end
		return acc;
	endfunction

	task automatic cluster_on_word(load_word_t w);
		int k, n, dims, cap, passes, best;
		bit conv, moved;
		longint sums[NCLU][NDIM];
		int cnt[NCLU];
		longint bd, dd;
		label_t r;
		coord_store[load_pos] = w.coord;
		load_pos = (load_pos + 1) % DEPTH;
		if (!w.fin)
			return;
		load_pos = 0;
		k = clampi(k_reg, 1, NCLU);
		n = clampi(n_reg, 1, NPTS);
		dims = clampi(d_reg, 1, NDIM);
		cap = clampi(cap_reg, 1, 255);
		for (int p = 0; p < n; p++)
			member_of[p] = 4'(p % k);
		passes = 0;
		conv = 0;
		while (passes < cap) begin
			moved = 0;
			for (int c = 0; c < NCLU; c++) begin
				cnt[c] = 0;
				for (int d = 0; d < NDIM; d++)
					sums[c][d] = 0;
			end
			for (int p = 0; p < n; p++) begin
				cnt[member_of[p]]++;
				for (int d = 0; d < dims; d++)
					sums[member_of[p]][d] += coord_store[p * dims + d];
			end
			for (int c = 0; c < k; c++)
				for (int d = 0; d < dims; d++)
					centroid[c][d] = cnt[c] != 0 ? sums[c][d] / cnt[c] : 0;
			for (int p = 0; p < n; p++) begin
				best = int'(member_of[p]);
				bd = sq_dist(p, best, dims);
				for (int c = 0; c < k; c++) begin
					if (cnt[c] == 0)
						continue;
					dd = sq_dist(p, c, dims);
					if (dd < bd) begin
						bd = dd;
						best = c;
					end
				end
				if (best != member_of[p]) begin
					member_of[p] = 4'(best);
					moved = 1;
				end
			end
			passes++;
			if (!moved) begin
				conv = 1;
				break;
			end
		end
		for (int p = 0; p < n; p++) begin
			r.idx = 6'(p);
			r.cl = member_of[p];
			r.passes = 8'(passes);
			r.conv = conv;
			r.last = (p == n - 1);
			label_q.insert(label_q.size(), r);
		end
		runs_done++;
	endtask

	task automatic report(string what);
		errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// driver
	always @(posedge clk) begin
		load_word_t w;
		if (start && !busy) begin
			cluster_on_word('{coordinate, final_coord});
			words_sent++;
		end
		sender_idle = words_sent < 153 ? 11 : (words_sent < 306 ? 56 : 0);
		if (!start || !busy) begin
			if (load_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
				w = load_q.pop_front();
				start <= 1;
				coordinate <= w.coord;
				final_coord <= w.fin;
			end else begin
				start <= 0;
			end
		end
	end

	// config shadow
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				km_pkg::CFG_CLUSTERS: k_reg = cfg_data[4:0];
				km_pkg::CFG_POINTS: n_reg = cfg_data[6:0];
				km_pkg::CFG_DIMENSIONS: d_reg = cfg_data[3:0];
				km_pkg::CFG_ITER_CAP: cap_reg = cfg_data;
				default: cap_reg = cap_reg;
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		label_t e;
		if (arst_n && result_valid) begin
			labels_seen++;
			if (label_q.size() == 0) begin
				report($sformatf("unexpected word point %0d", point_index));
			end else begin
				e = label_q.pop_front();
				if (point_index !== e.idx)
					report($sformatf("point_index %0d exp %0d", point_index, e.idx));
				if (cluster_id !== e.cl)
					report($sformatf("pt %0d cluster_id %0d exp %0d", e.idx, cluster_id, e.cl));
				if (passes_run !== e.passes)
					report($sformatf("pt %0d passes_run %0d exp %0d", e.idx, passes_run,
						e.passes));
				if (converged !== e.conv)
					report($sformatf("pt %0d converged %0b exp %0b", e.idx, converged, e.conv));
				if (end_of_run !== e.last)
					report($sformatf("pt %0d end_of_run %0b exp %0b", e.idx, end_of_run,
						e.last));
			end
		end
	end

	task automatic settle();
		do @(posedge clk);
		while (load_q.size() != 0 || start || label_q.size() != 0 || busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic set_cfg(logic [7:0] k, logic [7:0] n, logic [7:0] d, logic [7:0] cap);
		settle();
		cfg_write(km_pkg::CFG_CLUSTERS, k);
		cfg_write(km_pkg::CFG_POINTS, n);
		cfg_write(km_pkg::CFG_DIMENSIONS, d);
		cfg_write(km_pkg::CFG_ITER_CAP, cap);
	endtask

	// words for one set; count is the number loaded, last one marked final
	task automatic push_set(int count, int groups, int spread);
		int ctr[4];
		int v;
		load_word_t w;
		for (int g = 0; g < 4; g++)
			ctr[g] = $urandom_range(65535) - 32768;
		for (int i = 0; i < count; i++) begin
			v = groups == 0 ? $urandom_range(65535) - 32768
				: clampi(ctr[$urandom_range(groups - 1)] + $urandom_range(2 * spread) - spread,
					-32768, 32767);
			w.coord = 16'(v);
			w.fin = (i == count - 1);
			load_q.insert(load_q.size(), w);
		end
	endtask

	task automatic push_list(int vals[$]);
		load_word_t w;
		foreach (vals[i]) begin
			w.coord = 16'(vals[i]);
			w.fin = (i == vals.size() - 1);
			load_q.insert(load_q.size(), w);
		end
	endtask

	initial begin
		int k, n, d, cap, cnt;
		bit noise_ok;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// defaults: k=2, 64 points, 3 dims
		push_set(192, 2, 300);
		// one point, one cluster, extremes of the coordinate range
		set_cfg(1, 1, 2, 1);
		push_list('{-32768, 32767});
		// two identical points: ties keep their cluster; empty clusters ignored
		set_cfg(5, 2, 1, 255);
		push_list('{7, 7});
		set_cfg(3, 4, 2, 8);
		push_list('{-32768, -32768, 32767, 32767, -1, 0, 0, -1});
		// clamps: k 31->16, points 127->64, dims 0->1, cap 0->1
		set_cfg(8'hFF, 8'h7F, 8'h00, 0);
		push_set(64, 4, 2000);
		// widest set, 16 clusters
		set_cfg(16, 64, 1, 255);
		push_set(64, 4, 50);
		set_cfg(2, 2, 8, 255);
		push_set(16, 0, 0);
		settle();

		// random part; the low store addresses are written now, so short sets are legal
		while (words_sent + load_q.size() < 460) begin
			if ($urandom_range(7) == 0) begin
				k = $urandom_range(255);
				cap = $urandom_range(255);
			end else begin
				k = $urandom_range(1, 6);
				cap = $urandom_range(0, 40);
			end
			n = $urandom_range(0, 10) | ($urandom_range(1) << 7);
			d = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
			d = d | ($urandom_range(15) << 4);
			set_cfg(8'(k), 8'(n), 8'(d), 8'(cap));
			cnt = clampi(n & 8'h7F, 1, NPTS) * clampi(d & 8'hF, 1, NDIM);
			noise_ok = $urandom_range(5) == 0;
			if (noise_ok)
				cnt = clampi(cnt + $urandom_range(6) - 3, 1, DEPTH - 1);
			push_set(cnt, $urandom_range(4), $urandom_range(1, 4000));
		end
		settle();
		$display("run covered %0d clustering runs and %0d result words", runs_done,
			labels_seen);
		$display("sender idle 11%%, 56%%, then none; config extremes and clamps exercised");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
